// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked property, checked only out of reset
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked at every edge including reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/ps2f_pkg.sv =====
// shared types, constants and helpers for the ps2 frame receiver
package ps2f_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [15:0] TIMEOUT_RESET = 16'd250;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [3:0]  FRAME_BITS    = 4'd11;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_EDGE = 2'd1,
        ACT_READ = 2'd2
    } action_t;

    // completed byte from the frame assembler
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } push_t;

    function automatic ptr_t ring_next(input ptr_t idx);
        ptr_t n;
        if (idx == PTR_W'(FIFO_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = idx + 1'b1;
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/ps2f_ram.sv =====
// simple dual-port ram, one write and one registered read port
module ps2f_ram #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ps2f_frame.sv =====
// ps2 frame assembler: bit counter, shift byte, idle tick counter, timeout register
module ps2f_frame
    import ps2f_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        tick_en,
    input  logic        edge_en,
    input  logic        data_bit,
    output push_t       push
);

    logic [15:0] timeout_reg, timeout_next;
    logic [15:0] idle_reg, idle_next;
    logic [3:0]  count_reg, count_next;
    logic [7:0]  shift_reg, shift_next;

    logic        timed_out;
    logic [3:0]  cnt_base;
    logic [3:0]  cnt_inc;
    logic [7:0]  sh_base;

    assign timed_out = idle_reg > timeout_reg;

    always_comb begin
        timeout_next = cfg_wr_en ? cfg_wr_data : timeout_reg;
        idle_next    = idle_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        push         = '0;

        // a long gap throws away the partial frame
        cnt_base = timed_out ? 4'd0 : count_reg;
        sh_base  = timed_out ? 8'd0 : shift_reg;
        if (cnt_base inside {[4'd1:4'd8]}) begin
            sh_base[3'(cnt_base - 4'd1)] = data_bit;
        end
        cnt_inc = cnt_base + 4'd1;

        if (tick_en) begin
            if (idle_reg != IDLE_MAX) begin
                idle_next = idle_reg + 16'd1;
            end
        end else if (edge_en) begin
            idle_next = '0;
            if (cnt_inc >= FRAME_BITS) begin
                push.valid = 1'b1;
                push.data  = sh_base;
                count_next = '0;
                shift_next = '0;
            end else begin
                count_next = cnt_inc;
                shift_next = sh_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            idle_reg    <= '0;
            count_reg   <= '0;
            shift_reg   <= '0;
        end else begin
            timeout_reg <= timeout_next;
            idle_reg    <= idle_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
        end
    end

endmodule

// ===== hw/rtl/ps2f_pkg_unused_guard.sv =====
// fifo pointer and overflow control for the receive fifo
module ps2f_fifo_ctrl
    import ps2f_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    input  logic  read_en,
    output logic  wr_en,
    output ptr_t  wr_addr,
    output logic  rd_en,
    output ptr_t  rd_addr,
    output logic  ovf_out
);

    ptr_t head_reg, head_next;
    ptr_t tail_reg, tail_next;
    logic ovf_reg, ovf_next;
    logic full;

    assign wr_addr = ring_next(head_reg);
    assign rd_addr = ring_next(tail_reg);
    assign full    = wr_addr == tail_reg;
    assign wr_en   = push.valid && !full;
    // an entry is read only after it was written on an earlier edge
    assign rd_en   = read_en && (tail_reg != head_reg);
    assign ovf_out = ovf_reg;

    always_comb begin
        head_next = wr_en ? wr_addr : head_reg;
        tail_next = rd_en ? rd_addr : tail_reg;
        ovf_next  = ovf_reg;
        if (read_en) begin
            ovf_next = 1'b0;
        end else if (push.valid && full) begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

// ===== hw/rtl/ps2_frame_receiver_fifo_core.sv =====
// top level of the ps2 frame receiver with receive fifo
// One item is accepted every cycle while s_tready is high. Ticks and clock edges give no
// result; a read request gives one result, through the registered read of the fifo memory
// and then the output register. The fifo memory holds FIFO_DEPTH entries of which
// FIFO_DEPTH-1 are usable, is not cleared after reset, and only entries written by a
// completed frame are ever read. Writes and reads never hit the same entry in one cycle,
// so no forwarding is needed. A stalled output holds at most one further read result in
// the pipeline before s_tready drops.
`include "assert_macros.svh"

module ps2_frame_receiver_fifo_core
    import ps2f_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // timeout_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [0] data_bit, rest zero
    input  logic [1:0]  s_tuser,      // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata       // [7:0] byte_out, [8] available, [9] overflowed
);

    logic  s_accept;
    logic  out_move;
    logic  is_read;
    push_t push;
    logic  wr_en;
    ptr_t  wr_addr;
    logic  rd_en;
    ptr_t  rd_addr;
    logic  ovf;
    logic [7:0] ram_rdata;

    logic       p1_valid_reg, p1_valid_next;
    logic       p1_avail_reg;
    logic       p1_ovf_reg;
    logic       m_valid_reg, m_valid_next;
    logic [9:0] m_data_reg;

    assign out_move = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || out_move;
    assign s_accept = s_tvalid && s_tready;
    assign is_read  = s_accept && (s_tuser == ACT_READ);

    ps2f_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick_en     (s_accept && (s_tuser == ACT_TICK)),
        .edge_en     (s_accept && (s_tuser == ACT_EDGE)),
        .data_bit    (s_tdata[0]),
        .push        (push)
    );

    ps2f_fifo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .read_en (is_read),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .ovf_out (ovf)
    );

    ps2f_ram #(
        .DEPTH  (FIFO_DEPTH),
        .DATA_W (8)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (is_read) begin
            p1_valid_next = 1'b1;
        end else if (out_move) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = out_move ? p1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_read) begin
            p1_avail_reg <= rd_en;
            p1_ovf_reg   <= ovf;
        end
        if (out_move && p1_valid_reg) begin
            m_data_reg <= {p1_ovf_reg, p1_avail_reg, p1_avail_reg ? ram_rdata : 8'd0};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

    `ASSERT_CLK(a_no_same_entry, aclk, (wr_en && rd_en) |-> (wr_addr != rd_addr), "fifo read and write hit one entry")
    `ASSERT_CLKD(a_rdata_held, aclk, aresetn, (p1_valid_reg && !out_move) |=> $stable(ram_rdata), "read data changed while stalled")
    `ASSERT_CLKD(a_drop_sets_ovf, aclk, aresetn, (push.valid && !wr_en) |=> ovf, "dropped byte did not set overflow")
    `ASSERT_CLKD(a_read_clears_ovf, aclk, aresetn, is_read |=> !ovf, "read did not clear overflow")

endmodule
